FILE: src/erhf_pkg.sv
package erhf_pkg;

  localparam int unsigned MaxTagsDefault = 4;
  localparam int unsigned MacWidth       = 48;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  // Drop reasons.
  localparam logic [1:0] WHY_SHORT   = 2'd0;
  localparam logic [1:0] WHY_ADDRESS = 2'd1;
  localparam logic [1:0] WHY_TYPE    = 2'd2;
  localparam logic [1:0] WHY_TAGS    = 2'd3;

  // Protocols.
  localparam logic PROTO_IPV4 = 1'b0;
  localparam logic PROTO_IPV6 = 1'b1;

  // EtherType values.
  localparam logic [15:0] ETYPE_CTAG = 16'h8100;
  localparam logic [15:0] ETYPE_STAG = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] BCAST_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] drop_reason;
    logic       protocol;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

FILE: src/erhf_ifs.sv
interface erhf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface erhf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] drop_reason;
  logic       protocol;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output drop_reason, output protocol,
                  output payload_byte, output last, input ready);
  modport sink (input valid, input kind, input drop_reason, input protocol,
                input payload_byte, input last, output ready);
endinterface

interface erhf_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] station_mac;

  modport source (output valid, output station_mac, input ready);
  modport sink (input valid, input station_mac, output ready);
endinterface

FILE: src/ethernet_rx_header_filter.sv
// Ethernet receive header filter with VLAN tag stripping.
// Throughput: one byte per cycle; a new byte is taken whenever the result
// register is empty or is being emptied in the same cycle.
// Latency: a result is valid in the cycle after its byte's transaction.
// Reset (rst_ni low, asynchronous) clears the station address to zero,
// returns the parser to the start of a header and empties the result register.
module ethernet_rx_header_filter #(
  parameter int unsigned MAX_TAGS = erhf_pkg::MaxTagsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  erhf_cfg_if.sink          cfg_i,
  erhf_in_if.sink           rx_i,
  erhf_res_if.source        res_o
);
  import erhf_pkg::*;

  logic [MacWidth-1:0] station_mac_q;
  logic                accept;
  logic                pres_valid;
  res_t                pres;
  logic                res_valid_q;
  res_t                res_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_mac_q <= '0;
    end else if (cfg_i.valid) begin
      station_mac_q <= cfg_i.station_mac;
    end
  end

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  erhf_parser #(
    .MAX_TAGS (MAX_TAGS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (rx_i.data_byte),
    .frame_end_i   (rx_i.frame_end),
    .station_mac_i (station_mac_q),
    .res_valid_o   (pres_valid),
    .res_o         (pres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      res_valid_q <= accept && pres_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pres_valid) begin
      res_q <= pres;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.drop_reason  = res_q.drop_reason;
  assign res_o.protocol     = res_q.protocol;
  assign res_o.payload_byte = res_q.payload_byte;
  assign res_o.last         = res_q.last;

`ifndef NO_ASSERTIONS
  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.kind == KIND_DROP || res_q.kind == KIND_EMPTY) |-> res_q.last)
    else $error("drop or empty result without last");
  a_no_bad_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.kind != 2'd3)
    else $error("undefined result kind");
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |-> !rx_i.ready)
    else $error("input taken while a result is stalled");
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pres_valid |=> res_valid_q)
    else $error("result lost after its transaction");
`endif

endmodule

FILE: src/erhf_parser.sv
module erhf_parser #(
  parameter int unsigned MAX_TAGS = erhf_pkg::MaxTagsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          frame_end_i,
  input  logic [erhf_pkg::MacWidth-1:0] station_mac_i,
  output logic                          res_valid_o,
  output erhf_pkg::res_t                res_o
);
  import erhf_pkg::*;

  localparam int unsigned TagW = $clog2(MAX_TAGS + 1);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_IPV4    = 3'd2;
  localparam logic [2:0] PH_IPV6    = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  logic [2:0]      phase_q, phase_d;
  logic [3:0]      pos_q, pos_d;
  logic            own_q, own_d;
  logic            bcast_q, bcast_d;
  logic [15:0]     type_q, type_d;
  logic [TagW-1:0] tags_q, tags_d;

  logic [7:0]  mine_byte;
  logic [15:0] type_shifted;
  logic [15:0] type_new;
  logic        own_new, bcast_new;
  logic        decide;
  logic        do_drop;
  logic [1:0]  drop_why;
  logic        do_restart;

  always_comb begin
    case (pos_q[2:0])
      3'd0:    mine_byte = station_mac_i[47:40];
      3'd1:    mine_byte = station_mac_i[39:32];
      3'd2:    mine_byte = station_mac_i[31:24];
      3'd3:    mine_byte = station_mac_i[23:16];
      3'd4:    mine_byte = station_mac_i[15:8];
      default: mine_byte = station_mac_i[7:0];
    endcase
  end

  assign type_shifted = {type_q[7:0], data_byte_i};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    own_d       = own_q;
    bcast_d     = bcast_q;
    type_d      = type_q;
    tags_d      = tags_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    own_new     = own_q;
    bcast_new   = bcast_q;
    type_new    = type_q;
    decide      = 1'b0;
    do_drop     = 1'b0;
    drop_why    = WHY_SHORT;
    do_restart  = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        if (pos_q < 4'd6) begin
          own_new   = own_q & (data_byte_i == mine_byte);
          bcast_new = bcast_q & (data_byte_i == BCAST_BYTE);
        end
        if (pos_q >= 4'd12) begin
          type_new = type_shifted;
        end
        if (pos_q < 4'd13) begin
          if (frame_end_i) begin
            do_drop  = 1'b1;
            drop_why = WHY_SHORT;
          end else begin
            pos_d   = pos_q + 4'd1;
            own_d   = own_new;
            bcast_d = bcast_new;
            type_d  = type_new;
          end
        end else if (!own_new && !bcast_new) begin
          do_drop  = 1'b1;
          drop_why = WHY_ADDRESS;
        end else begin
          decide = 1'b1;
        end
      end
      PH_TAG: begin
        if (pos_q >= 4'd2) begin
          type_new = type_shifted;
        end
        if (pos_q < 4'd3) begin
          if (frame_end_i) begin
            do_drop  = 1'b1;
            drop_why = WHY_SHORT;
          end else begin
            pos_d  = pos_q + 4'd1;
            type_d = type_new;
          end
        end else begin
          decide = 1'b1;
        end
      end
      PH_IPV4, PH_IPV6: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.protocol     = (phase_q == PH_IPV6) ? PROTO_IPV6 : PROTO_IPV4;
        res_o.payload_byte = data_byte_i;
        res_o.last         = frame_end_i;
        do_restart         = frame_end_i;
      end
      default: begin
        do_restart = frame_end_i;
      end
    endcase

    if (decide) begin
      if (type_new == ETYPE_CTAG || type_new == ETYPE_STAG) begin
        if (frame_end_i) begin
          do_drop  = 1'b1;
          drop_why = WHY_SHORT;
        end else if (tags_q >= TagW'(MAX_TAGS)) begin
          do_drop  = 1'b1;
          drop_why = WHY_TAGS;
        end else begin
          tags_d  = tags_q + TagW'(1);
          phase_d = PH_TAG;
          pos_d   = 4'd0;
          type_d  = '0;
        end
      end else if (type_new == ETYPE_IPV4 || type_new == ETYPE_IPV6) begin
        if (frame_end_i) begin
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_EMPTY;
          res_o.protocol = (type_new == ETYPE_IPV6) ? PROTO_IPV6 : PROTO_IPV4;
          res_o.last     = 1'b1;
          do_restart     = 1'b1;
        end else begin
          phase_d = (type_new == ETYPE_IPV6) ? PH_IPV6 : PH_IPV4;
          pos_d   = 4'd0;
          type_d  = type_new;
        end
      end else begin
        do_drop  = 1'b1;
        drop_why = WHY_TYPE;
      end
    end

    if (do_drop) begin
      res_valid_o       = 1'b1;
      res_o.kind        = KIND_DROP;
      res_o.drop_reason = drop_why;
      res_o.last        = 1'b1;
      do_restart        = 1'b1;
    end

    if (do_restart) begin
      phase_d = PH_HEADER;
      pos_d   = 4'd0;
      own_d   = 1'b1;
      bcast_d = 1'b1;
      type_d  = '0;
      tags_d  = '0;
    end

    // An early drop swallows the rest of the frame.
    if (do_drop && !frame_end_i) begin
      phase_d = PH_DISCARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= 4'd0;
      own_q   <= 1'b1;
      bcast_q <= 1'b1;
      type_q  <= '0;
      tags_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      own_q   <= own_d;
      bcast_q <= bcast_d;
      type_q  <= type_d;
      tags_q  <= tags_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_tags_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tags_q <= TagW'(MAX_TAGS))
    else $error("tag count exceeds its bound");
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && frame_end_i |=> phase_q == PH_HEADER && pos_q == 4'd0 && tags_q == '0)
    else $error("frame end did not return the parser to the header");
  a_header_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TAG |-> pos_q <= 4'd3)
    else $error("tag byte position out of range");
`endif

endmodule

FILE: sim/ethernet_rx_header_filter_tb.sv
`timescale 1ns / 100ps

module ethernet_rx_header_filter_tb;
  import erhf_pkg::*;

  localparam int unsigned TagLimit = 4;
  localparam logic [1:0] NO_REASON = 2'd0;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] OWN_MAC = 48'h02A4_5B7C_19E3;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_TAG,
    ST_IPV4,
    ST_IPV6,
    ST_DISCARD
  } parse_state_e;

  class rx_filter_scoreboard;
    logic [47:0] station_mac;
    parse_state_e state;
    int unsigned pos;
    bit own_ok;
    bit bcast_ok;
    logic [15:0] ethertype;
    int unsigned tags;
    res_t expected_q[$];
    int errors;

    function new();
      station_mac = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      state = ST_HEADER;
      pos = 0;
      own_ok = 1'b1;
      bcast_ok = 1'b1;
      ethertype = '0;
      tags = 0;
    endfunction

    function void expect_result(logic [1:0] kind, logic [1:0] why, logic proto,
                                logic [7:0] data, logic last);
      res_t r;
      r.kind = kind;
      r.drop_reason = why;
      r.protocol = proto;
      r.payload_byte = data;
      r.last = last;
      expected_q.push_back(r);
    endfunction

    // A drop ends the frame at once, or swallows whatever bytes remain.
    function void drop(logic [1:0] why, bit fin);
      expect_result(KIND_DROP, why, PROTO_IPV4, 8'h00, 1'b1);
      restart();
      if (!fin) state = ST_DISCARD;
    endfunction

    function void decide_type(bit fin);
      logic proto;
      if (ethertype == ETYPE_CTAG || ethertype == ETYPE_STAG) begin
        if (fin) begin
          drop(WHY_SHORT, 1'b1);
        end else if (tags >= TagLimit) begin
          drop(WHY_TAGS, 1'b0);
        end else begin
          tags++;
          state = ST_TAG;
          pos = 0;
          ethertype = '0;
        end
      end else if (ethertype == ETYPE_IPV4 || ethertype == ETYPE_IPV6) begin
        proto = (ethertype == ETYPE_IPV6) ? PROTO_IPV6 : PROTO_IPV4;
        if (fin) begin
          expect_result(KIND_EMPTY, NO_REASON, proto, 8'h00, 1'b1);
          restart();
        end else begin
          state = (proto == PROTO_IPV6) ? ST_IPV6 : ST_IPV4;
          pos = 0;
        end
      end else begin
        drop(WHY_TYPE, fin);
      end
    endfunction

    function void note_byte(logic [7:0] b, bit fin);
      case (state)
        ST_HEADER: begin
          if (pos < 6) begin
            if (b != station_mac[8*(5-pos) +: 8]) own_ok = 1'b0;
            if (b != BCAST_BYTE) bcast_ok = 1'b0;
          end else if (pos >= 12) begin
            ethertype = {ethertype[7:0], b};
          end
          if (pos < 13) begin
            if (fin) drop(WHY_SHORT, 1'b1);
            else pos++;
          end else if (!own_ok && !bcast_ok) begin
            drop(WHY_ADDRESS, fin);
          end else begin
            decide_type(fin);
          end
        end
        ST_TAG: begin
          if (pos >= 2) ethertype = {ethertype[7:0], b};
          if (pos < 3) begin
            if (fin) drop(WHY_SHORT, 1'b1);
            else pos++;
          end else begin
            decide_type(fin);
          end
        end
        ST_IPV4, ST_IPV6: begin
          expect_result(KIND_PAYLOAD, NO_REASON,
                        (state == ST_IPV6) ? PROTO_IPV6 : PROTO_IPV4, b, fin);
          if (fin) restart();
        end
        default: begin
          if (fin) restart();
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("drop_reason", want.drop_reason, got.drop_reason);
      compare_field("protocol", want.protocol, got.protocol);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit steady;
  int unsigned bytes_sent;
  logic [7:0] frame_q[$];
  rx_filter_scoreboard sb = new();

  erhf_cfg_if cfg_if ();
  erhf_in_if rx_if ();
  erhf_res_if res_if ();

  ethernet_rx_header_filter #(
    .MAX_TAGS(TagLimit)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random back-pressure, checking at the rising edge.
  initial res_if.ready = 1'b0;
  always @(negedge clk) begin
    res_if.ready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.drop_reason = res_if.drop_reason;
      got.protocol = res_if.protocol;
      got.payload_byte = res_if.payload_byte;
      got.last = res_if.last;
      sb.check_result(got);
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic rx_send(logic [7:0] data, bit fin);
    while (!steady && $urandom_range(99) < 38) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data_byte <= data;
    rx_if.frame_end <= fin;
    do @(posedge clk); while (!rx_if.ready);
    sb.note_byte(data, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(bit close);
    for (int i = 0; i < frame_q.size(); i++) begin
      rx_send(frame_q[i], close && (i == frame_q.size() - 1));
    end
    frame_q.delete();
  endtask

  task automatic cfg_write(logic [47:0] mac);
    cfg_if.valid <= 1'b1;
    cfg_if.station_mac <= mac;
    do @(posedge clk); while (!cfg_if.ready);
    sb.station_mac = mac;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stops the byte stream and waits for the last results to drain.
  task automatic settle();
    int guard;
    guard = 0;
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic push_rand(int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic push16(logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic push_mac(logic [47:0] mac);
    for (int i = 5; i >= 0; i--) frame_q.push_back(mac[8*i +: 8]);
  endtask

  task automatic push_header(logic [47:0] dst, logic [15:0] etype);
    push_mac(dst);
    push_rand(6);
    push16(etype);
  endtask

  task automatic push_tag(logic [15:0] inner);
    push_rand(2);
    push16(inner);
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned ntags;
    logic [47:0] dst;
    logic [15:0] etype;
    r = $urandom_range(99);
    if (r < 6) begin
      // Line noise: random bytes of random length.
      push_rand($urandom_range(1, 30));
      send_frame(1'b1);
      return;
    end
    r = $urandom_range(99);
    if (r < 40) dst = sb.station_mac;
    else if (r < 65) dst = BCAST_MAC;
    else if (r < 80) dst = {16'($urandom), 32'($urandom)};
    else dst = ($urandom_range(1) ? sb.station_mac : BCAST_MAC) ^ (48'h1 << $urandom_range(47));
    r = $urandom_range(99);
    if (r < 50) ntags = 0;
    else if (r < 70) ntags = 1;
    else if (r < 85) ntags = $urandom_range(2, TagLimit);
    else ntags = $urandom_range(TagLimit + 1, TagLimit + 2);
    r = $urandom_range(99);
    if (r < 40) etype = ETYPE_IPV4;
    else if (r < 80) etype = ETYPE_IPV6;
    else etype = 16'($urandom);
    push_mac(dst);
    push_rand(6);
    for (int i = 0; i < ntags; i++) begin
      push16($urandom_range(1) ? ETYPE_CTAG : ETYPE_STAG);
      push_rand(2);
    end
    push16(etype);
    push_rand(($urandom_range(99) < 5) ? 40 : $urandom_range(0, 12));
    if ($urandom_range(99) < 10) begin
      r = $urandom_range(1, frame_q.size());
      while (frame_q.size() > r) void'(frame_q.pop_back());
    end
    send_frame(1'b1);
  endtask

  initial begin
    logic [47:0] phase_mac[4];
    int unsigned target;
    steady = 1'b0;
    bytes_sent = 0;
    rst_n = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.data_byte = '0;
    rx_if.frame_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.station_mac = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    cfg_write(OWN_MAC);

    // Accepted frames, own and broadcast address, with extreme payload bytes.
    push_header(OWN_MAC, ETYPE_IPV4);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h5A);
    send_frame(1'b1);
    push_header(BCAST_MAC, ETYPE_IPV6);
    push_rand(2);
    send_frame(1'b1);
    push_header(OWN_MAC, ETYPE_IPV4);
    send_frame(1'b1);

    // Address mismatch, with trailing bytes and ending on the type byte.
    push_header(OWN_MAC ^ 48'h1, ETYPE_IPV6);
    push_rand(3);
    send_frame(1'b1);
    push_header(48'h0, ETYPE_IPV4);
    send_frame(1'b1);

    // Short headers; a short frame is reported even when the address is foreign.
    push_mac(OWN_MAC);
    push_rand(3);
    send_frame(1'b1);
    frame_q.push_back(8'hFF);
    send_frame(1'b1);
    push_mac(48'h1234_5678_9ABC);
    push_rand(6);
    frame_q.push_back(8'h08);
    send_frame(1'b1);

    // Unsupported types.
    push_header(OWN_MAC, 16'h0806);
    push_rand(4);
    send_frame(1'b1);
    push_header(BCAST_MAC, 16'h88B5);
    send_frame(1'b1);

    // Tag stripping.
    push_header(OWN_MAC, ETYPE_CTAG);
    push_tag(ETYPE_IPV4);
    push_rand(2);
    send_frame(1'b1);
    push_header(BCAST_MAC, ETYPE_STAG);
    push_tag(ETYPE_CTAG);
    push_tag(ETYPE_IPV6);
    push_rand(1);
    send_frame(1'b1);
    push_header(OWN_MAC, ETYPE_CTAG);
    push_tag(16'h1234);
    push_rand(2);
    send_frame(1'b1);

    // Tag bound: the full number of tags passes, one more is dropped.
    push_header(OWN_MAC, ETYPE_CTAG);
    repeat (TagLimit - 1) push_tag(ETYPE_STAG);
    push_tag(ETYPE_IPV4);
    push_rand(1);
    send_frame(1'b1);
    push_header(OWN_MAC, ETYPE_STAG);
    repeat (TagLimit) push_tag(ETYPE_CTAG);
    push_tag(ETYPE_IPV4);
    push_rand(2);
    send_frame(1'b1);

    // Short tags: end on a tag type, end inside a tag, and end on a tag type
    // past the bound, where the short frame wins.
    push_header(OWN_MAC, ETYPE_CTAG);
    send_frame(1'b1);
    push_header(OWN_MAC, ETYPE_CTAG);
    push_rand(2);
    send_frame(1'b1);
    push_header(BCAST_MAC, ETYPE_CTAG);
    repeat (TagLimit) push_tag(ETYPE_CTAG);
    send_frame(1'b1);

    // Empty payload after a tag.
    push_header(OWN_MAC, ETYPE_CTAG);
    push_tag(ETYPE_IPV6);
    send_frame(1'b1);

    // Station address rewritten between the address bytes of one frame.
    push_mac(OWN_MAC);
    while (frame_q.size() > 3) void'(frame_q.pop_back());
    send_frame(1'b0);
    settle();
    cfg_write({OWN_MAC[47:24], 24'hC0FFEE});
    frame_q.push_back(8'hC0);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'hEE);
    push_rand(6);
    push16(ETYPE_IPV4);
    push_rand(2);
    send_frame(1'b1);
    settle();

    phase_mac[0] = {16'($urandom), 32'($urandom)};
    phase_mac[1] = BCAST_MAC;
    phase_mac[2] = 48'h0;
    phase_mac[3] = {16'($urandom), 32'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(phase_mac[ph]);
      target = bytes_sent + 50;
      // The second phase runs without any idling on either side.
      steady = (ph == 1);
      while (bytes_sent < target) begin
        random_frame();
      end
      steady = 1'b0;
      settle();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
